// File: src/dtrt_pkg.sv
// Shared types and constants of the dirty tile rectangle tracker.
// Depends on nothing; used by the top level and the port checker.
package dtrt_pkg;

  // Fixed widths of the transaction fields
  localparam int COORD_W    = 12;
  localparam int MATH_W     = 14;
  localparam int RECT_X_W   = 9;
  localparam int RECT_Y_W   = 8;
  localparam int RECT_W_W   = 9;
  localparam int RECT_H_W   = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_FLD_W  = RECT_X_W + RECT_Y_W + RECT_W_W + RECT_H_W;
  localparam int OUT_DATA_W = 40;

  // Function codes carried in in_tuser
  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MCLIP,
    ST_MWALK,
    ST_FSTART,
    ST_FSCAN,
    ST_FROW,
    ST_FRUN,
    ST_FCALC,
    ST_FGEOM,
    ST_FEXT,
    ST_FFIN
  } dtrt_state_t;

endpackage

// File: src/dtrt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dtrt_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 15
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/dirty_tile_rect_tracker.sv
// Top level of the dirty tile rectangle tracker: sequencer, two tile-row banks.
// Depends on dtrt_pkg and dtrt_ram.
//
// Channel  Dir  Signals                         Contents
// in_      in   tvalid tready tdata tuser       mark rectangle or fetch request
// out_     out  tvalid tready tdata tuser tlast update rectangle, found, last
// cfg_     in   we wdata                        enabled
//
// A mark walks the tile rows, one tile row per cycle through the dirty bank's read
// port, and ends without a walk when it clips away. An enabled fetch scans for the
// lowest pending row, takes its lowest run of tiles and reads the rows below it for
// merging. Reset is synchronous and clears the per-row nonzero flags. A result
// waits in the output register while the next transaction is taken; a second fetch
// result stalls until that register is free.
module dirty_tile_rect_tracker #(
  parameter int TILE_SIZE     = 16,
  parameter int CANVAS_WIDTH  = 320,
  parameter int CANVAS_HEIGHT = 240
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // mark_x [11:0], mark_y [23:12], mark_w [35:24], mark_h [47:36]
  input  logic [dtrt_pkg::IN_DATA_W-1:0] in_tdata,
  // func [0]
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // rect_x [8:0], rect_y [16:9], rect_w [25:17], rect_h [33:26], zero [39:34]
  output logic [dtrt_pkg::OUT_DATA_W-1:0] out_tdata,
  // found [0]
  output logic [0:0]                     out_tuser,
  output logic                           out_tlast
);

  localparam int TILES_X = (CANVAS_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TILES_Y = (CANVAS_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int RA      = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
  localparam int RC      = $clog2(TILES_Y + 1);
  localparam int CA      = $clog2(TILES_X + 1);
  localparam int PMAX    = 2 * ((CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH
                                                               : CANVAS_HEIGHT)
                           + 2 * TILE_SIZE;
  localparam int PW      = $clog2(PMAX + 1);
  localparam int MW      = dtrt_pkg::MATH_W;
  localparam int CW_     = dtrt_pkg::COORD_W;

  localparam int RECT_X = dtrt_pkg::RECT_X_W;
  localparam int RECT_Y = dtrt_pkg::RECT_Y_W;
  localparam int RECT_W = dtrt_pkg::RECT_W_W;
  localparam int RECT_H = dtrt_pkg::RECT_H_W;

  localparam logic signed [MW-1:0] ONE_S   = MW'(1);
  localparam logic signed [MW-1:0] CWM1_S  = MW'(CANVAS_WIDTH - 1);
  localparam logic signed [MW-1:0] CHM1_S  = MW'(CANVAS_HEIGHT - 1);
  localparam logic signed [MW-1:0] TSM1_S  = MW'(TILE_SIZE - 1);
  localparam logic [PW-1:0]        CW_P    = PW'(CANVAS_WIDTH);
  localparam logic [PW-1:0]        CH_P    = PW'(CANVAS_HEIGHT);
  localparam logic [PW-1:0]        TS_P    = PW'(TILE_SIZE);
  localparam logic [RC-1:0]        TY_C    = RC'(TILES_Y);

  dtrt_pkg::dtrt_state_t state_r, state_nxt;

  logic                      enabled_r;
  logic                      psel_r, psel_nxt;
  logic [TILES_Y-1:0]        nz_r [2];
  logic [TILES_Y-1:0]        nz_nxt [2];

  // Captured request
  logic signed [CW_-1:0]     mx_r, my_r, mw_r, mh_r;

  // Mark datapath
  logic signed [MW-1:0]      xc_r, x1c_r, yc_r, y1c_r;
  logic signed [MW-1:0]      xc_nxt, x1c_nxt, yc_nxt, y1c_nxt;
  logic [RC-1:0]             mrow_r, mrow_nxt;
  logic [RA-1:0]             mrow_d_r, mrow_d_nxt;
  logic                      mdv_r, mdv_nxt;
  logic [TILES_X-1:0]        col_mask;

  // Fetch datapath
  logic [RA-1:0]             scan_r, scan_nxt;
  logic [RA-1:0]             row_r, row_nxt;
  logic [TILES_X-1:0]        v_r, v_nxt;
  logic [TILES_X-1:0]        run_r, run_nxt;
  logic [CA-1:0]             s_r, s_nxt, e_r, e_nxt;
  logic [PW-1:0]             x0_r, x0_nxt, w_r, w_nxt, cmp_r, cmp_nxt, h_r, h_nxt;
  logic [RC-1:0]             ext_r, ext_nxt;
  logic                      found_r, found_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic [dtrt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                      out_found_r, out_found_nxt;
  logic                      out_last_r, out_last_nxt;

  // Memory access
  logic                      mem_bank;
  logic                      mem_re, mem_we;
  logic [RA-1:0]             mem_raddr, mem_waddr;
  logic [TILES_X-1:0]        mem_wdata;
  logic                      rd_bank_r;
  logic [TILES_X-1:0]        rdata0, rdata1, rdata;

  assign in_tready  = (state_r == dtrt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  // Bank RAMs: pending and dirty swap roles through psel_r
  dtrt_ram #(.WIDTH(TILES_X), .DEPTH(TILES_Y)) u_bank0 (
    .clk   (clk),
    .we    (mem_we && !mem_bank),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re && !mem_bank),
    .raddr (mem_raddr),
    .rdata (rdata0)
  );

  dtrt_ram #(.WIDTH(TILES_X), .DEPTH(TILES_Y)) u_bank1 (
    .clk   (clk),
    .we    (mem_we && mem_bank),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re && mem_bank),
    .raddr (mem_raddr),
    .rdata (rdata1)
  );

  assign rdata = rd_bank_r ? rdata1 : rdata0;

  // Tile columns covered by the clipped mark
  always_comb begin
    logic signed [MW-1:0] lane_lo;
    for (int i = 0; i < TILES_X; i++) begin
      lane_lo     = MW'(i * TILE_SIZE);
      col_mask[i] = (lane_lo <= x1c_r) && ((lane_lo + TSM1_S) >= xc_r);
    end
  end

  // Sequencer: next state, memory requests and datapath updates
  always_comb begin
    logic signed [MW-1:0]  mx_e, my_e, mw_e, mh_e, x1, y1, xcl, ycl, x1cl, y1cl;
    logic signed [MW-1:0]  mrow_lo;
    logic                  mrow_cov;
    logic                  mark_ok;
    logic [TILES_X-1:0]    row_v;
    logic                  bank_n;
    logic [TILES_X-1:0]    s_oh;
    logic [TILES_X:0]      run_x, e_oh;
    logic [PW-1:0]         xe, y0, hc, w_c;
    logic [RC-1:0]         next_row;
    logic                  whole, fits;
    logic                  out_free;

    state_nxt     = state_r;
    psel_nxt      = psel_r;
    xc_nxt        = xc_r;
    x1c_nxt       = x1c_r;
    yc_nxt        = yc_r;
    y1c_nxt       = y1c_r;
    mrow_nxt      = mrow_r;
    mrow_d_nxt    = mrow_d_r;
    mdv_nxt       = 1'b0;
    scan_nxt      = scan_r;
    row_nxt       = row_r;
    v_nxt         = v_r;
    run_nxt       = run_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    x0_nxt        = x0_r;
    w_nxt         = w_r;
    cmp_nxt       = cmp_r;
    h_nxt         = h_r;
    ext_nxt       = ext_r;
    found_nxt     = found_r;
    mem_bank      = psel_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    out_free      = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    // Clip the mark rectangle to the canvas
    mx_e  = MW'(mx_r);
    my_e  = MW'(my_r);
    mw_e  = MW'(mw_r);
    mh_e  = MW'(mh_r);
    x1    = mx_e + mw_e - ONE_S;
    y1    = my_e + mh_e - ONE_S;
    xcl   = (mx_e < 0) ? '0 : mx_e;
    ycl   = (my_e < 0) ? '0 : my_e;
    x1cl  = (x1 > CWM1_S) ? CWM1_S : x1;
    y1cl  = (y1 > CHM1_S) ? CHM1_S : y1;
    mark_ok = (mw_e > 0) && (mh_e > 0) && (xcl <= x1cl) && (ycl <= y1cl);

    // Row coverage for the mark walk
    mrow_lo  = MW'(mrow_r * TILE_SIZE);
    mrow_cov = (mrow_lo <= y1c_r) && ((mrow_lo + TSM1_S) >= yc_r);

    // Run edges of the first pending row
    s_oh  = run_r & ~(run_r << 1);
    run_x = {1'b0, run_r};
    e_oh  = (run_x << 1) & ~run_x;

    // Pixel geometry
    xe       = PW'(e_r * TILE_SIZE);
    w_c      = (xe > CW_P) ? (CW_P - PW'(s_r * TILE_SIZE))
                           : (xe - PW'(s_r * TILE_SIZE));
    y0       = PW'(row_r * TILE_SIZE);
    hc       = ((y0 + h_r) > CH_P) ? (CH_P - y0) : h_r;
    next_row = ext_r + RC'(1);
    row_v    = '0;
    bank_n   = psel_r;
    whole    = 1'b0;
    fits     = 1'b0;

    unique case (state_r)
      dtrt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == dtrt_pkg::FUNC_FETCH) ? dtrt_pkg::ST_FSTART
                                                            : dtrt_pkg::ST_MCLIP;
        end
      end

      dtrt_pkg::ST_MCLIP: begin
        xc_nxt   = xcl;
        x1c_nxt  = x1cl;
        yc_nxt   = ycl;
        y1c_nxt  = y1cl;
        mrow_nxt = '0;
        state_nxt = mark_ok ? dtrt_pkg::ST_MWALK : dtrt_pkg::ST_IDLE;
      end

      dtrt_pkg::ST_MWALK: begin
        mem_bank = !psel_r;
        // Issue the read of the next covered row
        if (mrow_r < TY_C) begin
          mem_re     = mrow_cov;
          mem_raddr  = mrow_r[RA-1:0];
          mdv_nxt    = mrow_cov;
          mrow_d_nxt = mrow_r[RA-1:0];
          mrow_nxt   = mrow_r + RC'(1);
        end
        // Merge the covered columns into the row read last cycle
        if (mdv_r) begin
          row_v     = nz_r[!psel_r][mrow_d_r] ? rdata : '0;
          mem_we    = 1'b1;
          mem_waddr = mrow_d_r;
          mem_wdata = row_v | col_mask;
        end
        if ((mrow_r == TY_C) && !mdv_r) begin
          state_nxt = dtrt_pkg::ST_IDLE;
        end
      end

      dtrt_pkg::ST_FSTART: begin
        if (!enabled_r) begin
          state_nxt = dtrt_pkg::ST_IDLE;
        end else begin
          // Swap banks when the pending copy has run dry
          bank_n   = (~|nz_r[psel_r]) ? !psel_r : psel_r;
          psel_nxt = bank_n;
          scan_nxt = '0;
          if (~|nz_r[bank_n]) begin
            found_nxt = 1'b0;
            state_nxt = dtrt_pkg::ST_FFIN;
          end else begin
            found_nxt = 1'b1;
            state_nxt = dtrt_pkg::ST_FSCAN;
          end
        end
      end

      dtrt_pkg::ST_FSCAN: begin
        if (nz_r[psel_r][scan_r]) begin
          mem_re    = 1'b1;
          mem_raddr = scan_r;
          row_nxt   = scan_r;
          state_nxt = dtrt_pkg::ST_FROW;
        end else begin
          scan_nxt = scan_r + RA'(1);
        end
      end

      dtrt_pkg::ST_FROW: begin
        v_nxt     = rdata;
        state_nxt = dtrt_pkg::ST_FRUN;
      end

      dtrt_pkg::ST_FRUN: begin
        // Isolate the lowest run of set tiles
        run_nxt   = v_r & ~((v_r | (v_r - TILES_X'(1))) + TILES_X'(1));
        state_nxt = dtrt_pkg::ST_FCALC;
      end

      dtrt_pkg::ST_FCALC: begin
        s_nxt = '0;
        e_nxt = '0;
        for (int i = 0; i < TILES_X; i++) begin
          if (s_oh[i]) s_nxt = s_nxt | CA'(i);
        end
        for (int i = 0; i <= TILES_X; i++) begin
          if (e_oh[i]) e_nxt = e_nxt | CA'(i);
        end
        // Drop the run from its row
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = v_r & ~run_r;
        state_nxt = dtrt_pkg::ST_FGEOM;
      end

      dtrt_pkg::ST_FGEOM: begin
        x0_nxt  = PW'(s_r * TILE_SIZE);
        w_nxt   = w_c;
        cmp_nxt = w_c << 1;
        h_nxt   = TS_P;
        ext_nxt = RC'(row_r) + RC'(1);
        if ((RC'(row_r) + RC'(1)) < TY_C) begin
          mem_re    = 1'b1;
          mem_raddr = RA'(RC'(row_r) + RC'(1));
          state_nxt = dtrt_pkg::ST_FEXT;
        end else begin
          state_nxt = dtrt_pkg::ST_FFIN;
        end
      end

      dtrt_pkg::ST_FEXT: begin
        row_v = nz_r[psel_r][ext_r[RA-1:0]] ? rdata : '0;
        whole = ((row_v & run_r) == run_r);
        fits  = (cmp_r <= CW_P);
        if (whole && fits) begin
          // Merge this row into the rectangle
          mem_we    = 1'b1;
          mem_waddr = ext_r[RA-1:0];
          mem_wdata = row_v & ~run_r;
          h_nxt     = h_r + TS_P;
          cmp_nxt   = cmp_r + w_r;
          if (next_row < TY_C) begin
            mem_re    = 1'b1;
            mem_raddr = next_row[RA-1:0];
            ext_nxt   = next_row;
          end else begin
            state_nxt = dtrt_pkg::ST_FFIN;
          end
        end else begin
          state_nxt = dtrt_pkg::ST_FFIN;
        end
      end

      dtrt_pkg::ST_FFIN: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          if (found_r) begin
            out_data_nxt = dtrt_pkg::OUT_DATA_W'({RECT_H'(hc), RECT_W'(w_r),
                                                  RECT_Y'(y0), RECT_X'(x0_r)});
            out_last_nxt = ~|nz_r[psel_r];
          end else begin
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
          end
          state_nxt = dtrt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dtrt_pkg::ST_IDLE;
      end
    endcase

    // Keep the per-row nonzero flags in step with every write
    nz_nxt[0] = nz_r[0];
    nz_nxt[1] = nz_r[1];
    if (mem_we) begin
      nz_nxt[mem_bank][mem_waddr] = |mem_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtrt_pkg::ST_IDLE;
      enabled_r   <= 1'b0;
      psel_r      <= 1'b0;
      nz_r[0]     <= '0;
      nz_r[1]     <= '0;
      mdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      psel_r      <= psel_nxt;
      nz_r[0]     <= nz_nxt[0];
      nz_r[1]     <= nz_nxt[1];
      mdv_r       <= mdv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mx_r   <= in_tdata[11:0];
      my_r   <= in_tdata[23:12];
      mw_r   <= in_tdata[35:24];
      mh_r   <= in_tdata[47:36];
    end
    if (mem_re) begin
      rd_bank_r <= mem_bank;
    end
    xc_r        <= xc_nxt;
    x1c_r       <= x1c_nxt;
    yc_r        <= yc_nxt;
    y1c_r       <= y1c_nxt;
    mrow_r      <= mrow_nxt;
    mrow_d_r    <= mrow_d_nxt;
    scan_r      <= scan_nxt;
    row_r       <= row_nxt;
    v_r         <= v_nxt;
    run_r       <= run_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    x0_r        <= x0_nxt;
    w_r         <= w_nxt;
    cmp_r       <= cmp_nxt;
    h_r         <= h_nxt;
    ext_r       <= ext_nxt;
    found_r     <= found_nxt;
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// File: src/dtrt_checker.sv
// Port-level checker for the dirty tile rectangle tracker, with its bind.
// Depends on dtrt_pkg and the top level dirty_tile_rect_tracker.
module dtrt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dtrt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  // Leave reset idle, ready and with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("not idle after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

  // Take one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while busy");

  // An empty fetch reports zeros and last
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> ((out_tdata == '0) && out_tlast))
    else $error("empty fetch result not zero");

endmodule

bind dirty_tile_rect_tracker dtrt_checker u_dtrt_checker (.*);
